[sv/rlsr_pkg.sv]
`timescale 1ns / 1ps

package rlsr_pkg;

   localparam int MAX_GAP = 63;
   localparam int PIX_W   = 8;
   localparam int GAP_W   = 6;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             row_end_in;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_of_burst;
      logic             row_end_out;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic take;
      logic fetch_first;
      logic emit_buf;
      logic emit_tail;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic need_flush;
      logic has_more;
      logic tail_pending;
   } sts_type;

endpackage

[sv/rlsr_datapath.sv]
`timescale 1ns / 1ps

module rlsr_datapath #(
   parameter int MAX_GAP = rlsr_pkg::MAX_GAP
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rlsr_pkg::req_word_type        req_word,
   input  logic                          csr_wr_en,
   input  logic [rlsr_pkg::GAP_W-1:0]    csr_wr_data,
   input  rlsr_pkg::cmd_type             cmd,
   output rlsr_pkg::sts_type             sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rlsr_pkg::rsp_word_type        rsp_word
);

   localparam int LEN_W = $clog2(MAX_GAP + 1);
   localparam int IDX_W = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
   localparam int NXT_W = LEN_W + 1;
   localparam int CMP_W = LEN_W + 2;
   localparam int PIX_W = rlsr_pkg::PIX_W;
   localparam int GAP_W = rlsr_pkg::GAP_W;

   logic [GAP_W-1:0] max_gap_ff, max_gap_in;
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic             zero_seen_ff, zero_seen_in;
   logic             passing_ff, passing_in;

   logic [LEN_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic             fill_ff, fill_in;
   logic             tail_en_ff, tail_en_in;
   logic [PIX_W-1:0] tail_px_ff, tail_px_in;
   logic             row_end_ff, row_end_in;

   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [PIX_W-1:0] rd_data_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   rlsr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [PIX_W-1:0] run_mem [MAX_GAP];

   logic             px_zero, over, store;
   logic [CMP_W-1:0] gap, held_zs, grow_zs;
   logic [LEN_W-1:0] cnt_now;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [NXT_W-1:0] rd_next;
   logic             out_free;

   // decode of the offered word against current run state
   always_comb begin
      gap = (max_gap_ff > GAP_W'(MAX_GAP)) ? CMP_W'(MAX_GAP) : CMP_W'(max_gap_ff);
      held_zs = CMP_W'(run_len_ff) + CMP_W'(zero_seen_ff);
      grow_zs = held_zs + CMP_W'(1);
      px_zero = (req_word.pixel_in == '0);
      over    = !px_zero && !passing_ff &&
                ((grow_zs > gap) || (run_len_ff >= LEN_W'(MAX_GAP)));
      store   = !px_zero && !passing_ff && !over;
      if (px_zero || over) begin
         cnt_now = run_len_ff;
      end else if (store && req_word.row_end_in) begin
         cnt_now = run_len_ff + LEN_W'(1);
      end else begin
         cnt_now = '0;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_next  = NXT_W'(rd_idx_ff) + NXT_W'(1);

   always_comb begin
      sts.out_free     = out_free;
      sts.need_flush   = (cnt_now != '0);
      sts.has_more     = (rd_next < NXT_W'(flush_cnt_ff));
      sts.tail_pending = tail_en_ff;
   end

   always_comb begin
      max_gap_in   = csr_wr_en ? csr_wr_data : max_gap_ff;
      run_len_in   = run_len_ff;
      zero_seen_in = zero_seen_ff;
      passing_in   = passing_ff;
      flush_cnt_in = flush_cnt_ff;
      fill_in      = fill_ff;
      tail_en_in   = tail_en_ff;
      tail_px_in   = tail_px_ff;
      row_end_in   = row_end_ff;
      rd_idx_in    = rd_idx_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rd_next[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (cmd.take) begin
         flush_cnt_in = cnt_now;
         fill_in      = px_zero && (run_len_ff != '0) && (held_zs <= gap);
         tail_en_in   = !store;
         tail_px_in   = req_word.pixel_in;
         row_end_in   = req_word.row_end_in;
         wr_en        = store;
         run_len_in   = (store && !req_word.row_end_in) ? run_len_ff + LEN_W'(1) : '0;
         if (req_word.row_end_in) begin
            zero_seen_in = 1'b0;
            passing_in   = 1'b0;
         end else if (px_zero) begin
            zero_seen_in = 1'b1;
            passing_in   = 1'b0;
         end else if (over) begin
            passing_in   = 1'b1;
         end
         // nothing held: the word goes straight to the output register
         if (cnt_now == '0 && !store) begin
            rsp_valid_in              = 1'b1;
            rsp_word_in.pixel_out     = req_word.pixel_in;
            rsp_word_in.last_of_burst = 1'b1;
            rsp_word_in.row_end_out   = req_word.row_end_in;
         end
      end

      if (cmd.fetch_first) begin
         rd_en     = 1'b1;
         rd_addr   = '0;
         rd_idx_in = '0;
      end

      if (cmd.emit_buf) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.pixel_out     = fill_ff ? '0 : rd_data_ff;
         rsp_word_in.last_of_burst = !sts.has_more && !tail_en_ff;
         rsp_word_in.row_end_out   = !sts.has_more && !tail_en_ff && row_end_ff;
         if (sts.has_more) begin
            rd_en     = 1'b1;
            rd_idx_in = rd_next[IDX_W-1:0];
         end
      end

      if (cmd.emit_tail) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.pixel_out     = tail_px_ff;
         rsp_word_in.last_of_burst = 1'b1;
         rsp_word_in.row_end_out   = row_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff   <= '0;
         run_len_ff   <= '0;
         zero_seen_ff <= 1'b0;
         passing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_gap_ff   <= max_gap_in;
         run_len_ff   <= run_len_in;
         zero_seen_ff <= zero_seen_in;
         passing_ff   <= passing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_cnt_ff <= flush_cnt_in;
      fill_ff      <= fill_in;
      tail_en_ff   <= tail_en_in;
      tail_px_ff   <= tail_px_in;
      row_end_ff   <= row_end_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_word_ff  <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[run_len_ff[IDX_W-1:0]] <= req_word.pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= run_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_pass_empty : assert property (@(posedge clock) disable iff (reset)
      passing_ff |-> (run_len_ff == '0))
      else $error("pass-through mode with a run still held");

   a_row_clear : assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_word.row_end_in) |=>
         (!zero_seen_ff && !passing_ff && (run_len_ff == '0)))
      else $error("row state not cleared after end of row");

endmodule

[sv/rlsr_ctrl.sv]
`timescale 1ns / 1ps

module rlsr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlsr_pkg::sts_type sts,
   output rlsr_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_BUF   = 2'd2;
   localparam logic [1:0] ST_TAIL  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.take        = 1'b0;
      cmd.fetch_first = 1'b0;
      cmd.emit_buf    = 1'b0;
      cmd.emit_tail   = 1'b0;
      req_stall       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.take = 1'b1;
               if (sts.need_flush) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch_first = 1'b1;
            state_in        = ST_BUF;
         end
         ST_BUF: begin
            if (sts.out_free) begin
               cmd.emit_buf = 1'b1;
               if (!sts.has_more) begin
                  state_in = sts.tail_pending ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.emit_tail = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_flush_start : assert property (@(posedge clock) disable iff (reset)
      (cmd.take && sts.need_flush) |=> (state_ff == ST_FETCH))
      else $error("held run not fetched after word taken");

   a_tail_after : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_buf && !sts.has_more && sts.tail_pending) |=> (state_ff == ST_TAIL))
      else $error("pending pixel skipped after flush");

   a_out_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_buf || cmd.emit_tail || cmd.take) |-> sts.out_free)
      else $error("output register overwritten while stalled");

endmodule

[sv/run_length_smoothing_row.sv]
// A pixel that releases nothing held appears in the cycle after it is taken;
//   a pixel that joins the held run produces nothing and frees the input next cycle.
// Throughput while the output is not stalled: one pixel a cycle while runs are held or
//   passed through; a pixel that closes a run stalls the input for one buffer read
//   ahead, then one word a cycle from the registered read port, then an unstored closing pixel.
// Reset clears run state, mode flags, output valid and max_gap; the buffer is not cleared.
`timescale 1ns / 1ps

module run_length_smoothing_row #(
   parameter int MAX_GAP = rlsr_pkg::MAX_GAP
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rlsr_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rlsr_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_wr_en,
   input  logic [rlsr_pkg::GAP_W-1:0]    csr_wr_data
);

   rlsr_pkg::cmd_type cmd;
   rlsr_pkg::sts_type sts;

   rlsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rlsr_datapath #(
      .MAX_GAP (MAX_GAP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

[test/run_length_smoothing_row_tb.sv]
`timescale 1ns / 1ps

module run_length_smoothing_row_tb;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   rlsr_pkg::req_word_type        req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rlsr_pkg::rsp_word_type        rsp_word;
   logic                          csr_wr_en = 1'b0;
   logic [rlsr_pkg::GAP_W-1:0]    csr_wr_data = '0;

   // smoothing model state
   logic [rlsr_pkg::PIX_W-1:0]    held_px [rlsr_pkg::MAX_GAP];
   int                            held_cnt = 0;
   bit                            zero_in_row = 1'b0;
   bit                            passing = 1'b0;
   logic [rlsr_pkg::GAP_W-1:0]    gap_cfg = '0;
   logic [rlsr_pkg::PIX_W-1:0]    burst_px [$];

   rlsr_pkg::req_word_type        pixels_to_send [$];
   rlsr_pkg::rsp_word_type        expected_out [$];
   int                            mismatches = 0;

   int                 send_gap = 0;
   bit                 send_idle = 1'b1;
   int                 recv_stall_left = 0;
   bit                 recv_idle = 1'b1;
   bit                 long_hold_due = 1'b0;
   bit                 long_hold_done = 1'b0;
   int                 long_hold_left = 0;

   run_length_smoothing_row DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void release_held(input bit as_zero);
      for (int i = 0; i < held_cnt; i++)
         burst_px.insert(burst_px.size(), as_zero ? '0 : held_px[i]);
      held_cnt = 0;
   endfunction

   // works out the words one accepted pixel releases
   function automatic void smooth_pixel(input rlsr_pkg::req_word_type w);
      int                     zs;
      int                     gap;
      rlsr_pkg::rsp_word_type o;
      zs  = zero_in_row;
      gap = (gap_cfg > rlsr_pkg::MAX_GAP) ? rlsr_pkg::MAX_GAP : gap_cfg;
      if (w.pixel_in == 0) begin
         release_held(held_cnt > 0 && held_cnt + zs <= gap);
         burst_px.insert(burst_px.size(), '0);
         passing     = 1'b0;
         zero_in_row = 1'b1;
      end else if (passing) begin
         burst_px.insert(burst_px.size(), w.pixel_in);
      end else if (held_cnt + 1 + zs > gap || held_cnt >= rlsr_pkg::MAX_GAP) begin
         release_held(1'b0);
         burst_px.insert(burst_px.size(), w.pixel_in);
         passing = 1'b1;
      end else begin
         held_px[held_cnt] = w.pixel_in;
         held_cnt++;
      end
      if (w.row_end_in) begin
         release_held(1'b0);
         zero_in_row = 1'b0;
         passing     = 1'b0;
      end
      for (int i = 0; i < burst_px.size(); i++) begin
         o.pixel_out     = burst_px[i];
         o.last_of_burst = (i == burst_px.size() - 1);
         o.row_end_out   = (i == burst_px.size() - 1) && w.row_end_in;
         expected_out.insert(expected_out.size(), o);
      end
      burst_px.delete();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid)
            smooth_pixel(req_word);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixels_to_send.size() > 0) begin
            req_word  <= pixels_to_send.pop_front();
            req_valid <= 1'b1;
            if (send_idle && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      bit stall_next;
      stall_next = 1'b0;
      if (!reset) begin
         if (long_hold_due && !long_hold_done) begin
            long_hold_left = 400;
            long_hold_done = 1'b1;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            stall_next = 1'b1;
         end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            stall_next = 1'b1;
         end else if (recv_idle && $urandom_range(0, 7) == 0) begin
            recv_stall_left = $urandom_range(0, 12);
            stall_next      = 1'b1;
         end
      end
      rsp_stall <= stall_next;
   end

   task automatic report(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rlsr_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %p", $time, rsp_word);
            mismatches++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_word.pixel_out !== want.pixel_out)
               report("pixel_out", want.pixel_out, rsp_word.pixel_out);
            if (rsp_word.last_of_burst !== want.last_of_burst)
               report("last_of_burst", want.last_of_burst, rsp_word.last_of_burst);
            if (rsp_word.row_end_out !== want.row_end_out)
               report("row_end_out", want.row_end_out, rsp_word.row_end_out);
         end
      end
   end

   task automatic offer(input int px, input bit last);
      rlsr_pkg::req_word_type w;
      w.pixel_in   = px[rlsr_pkg::PIX_W-1:0];
      w.row_end_in = last;
      pixels_to_send.insert(pixels_to_send.size(), w);
   endtask

   task automatic set_gap(input int v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[rlsr_pkg::GAP_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gap_cfg = v[rlsr_pkg::GAP_W-1:0];
   endtask

   // held runs give no words, so keep waiting after the queues and the input have drained
   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_to_send.size() != 0 || req_valid || expected_out.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // runs sized around the current gap, mixed with stray pixels
   task automatic queue_rows(input int count);
      int lo;
      int run_len;
      while (count > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            offer($urandom_range(0, 255), $urandom_range(0, 3) == 0);
            count--;
         end else begin
            lo      = (gap_cfg > 2) ? int'(gap_cfg) - 2 : 1;
            run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(lo, int'(gap_cfg) + 2);
            for (int i = 0; i < run_len && count > 0; i++) begin
               offer($urandom_range(1, 255), $urandom_range(0, 29) == 0);
               count--;
            end
            if (count > 0) begin
               offer(0, $urandom_range(0, 7) == 0);
               count--;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_gap(3);
      offer(0, 0);
      offer(255, 0); offer(128, 0); offer(0, 0);
      offer(1, 0); offer(2, 0); offer(3, 0); offer(4, 0); offer(0, 0);
      offer(7, 1);
      offer(9, 0); offer(9, 0); offer(9, 0); offer(0, 0);
      offer(0, 1);
      wait_idle();

      // limit lowered under a held run, closed by a zero
      set_gap(63);
      offer(85, 0); offer(170, 0); offer(255, 0);
      wait_idle();
      set_gap(0);
      offer(0, 0); offer(1, 0); offer(254, 1);
      wait_idle();

      // same, closed by a nonzero word
      set_gap(63);
      offer(3, 0); offer(4, 0);
      wait_idle();
      set_gap(1);
      offer(5, 1);
      wait_idle();

      // longest burst: a full buffer flushed by one more pixel
      set_gap(63);
      for (int i = 0; i < 70; i++)
         offer($urandom_range(1, 255), 0);
      offer(0, 1);
      queue_rows(30);
      wait_idle();

      set_gap(1);
      queue_rows(50);
      wait_idle();

      set_gap(2);
      queue_rows(50);
      wait_idle();

      send_idle = 1'b0;
      recv_idle = 1'b0;
      set_gap(7);
      queue_rows(40);
      wait_idle();
      send_idle = 1'b1;
      recv_idle = 1'b1;

      set_gap(0);
      queue_rows(30);
      wait_idle();

      set_gap($urandom_range(3, 62));
      queue_rows(40);
      wait_idle();

      // receiver holds off while words keep coming
      send_idle = 1'b0;
      set_gap(4);
      long_hold_due = 1'b1;
      queue_rows(60);
      wait_idle();

      recv_idle = 1'b0;
      set_gap($urandom_range(0, 63));
      queue_rows(40);
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("run_length_smoothing_row test passed");
      else
         $display("run_length_smoothing_row test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("run_length_smoothing_row test failed");
      $finish;
   end

endmodule
